### rtl/ple_pkg.sv
// Types and constants shared by the positional list engine modules.
`default_nettype none
package ple_pkg;

	localparam int POS_W  = 5;
	localparam int DATA_W = 32;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_FIND   = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0]         length_after;
	} rsp_t;

	typedef struct packed {
		logic             ins_ok;
		logic             del_ok;
		logic [POS_W-1:0] position;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/ple_cell.sv
// One list cell: holds one entry and shifts toward either neighbor.
`default_nettype none
module ple_cell #(
	parameter int CAPACITY = 16,
	parameter int IDX      = 0
) (
	input  wire logic                             clk,
	input  wire ple_pkg::cell_ctrl_t              ctrl,
	input  wire logic [ple_pkg::DATA_W-1:0]       ins_value,
	input  wire logic [ple_pkg::DATA_W-1:0]       left_data,
	input  wire logic [ple_pkg::DATA_W-1:0]       right_data,
	output logic      [ple_pkg::DATA_W-1:0]       data,
	output logic      [ple_pkg::DATA_W-1:0]       hit_data
);
	import ple_pkg::*;

	localparam int IW = $clog2(CAPACITY) + 1;
	localparam int CW = (IW > POS_W) ? IW : POS_W;
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [CW-1:0]     pos_w;
	logic              at_pos;
	logic              above_pos;

	assign pos_w     = CW'(ctrl.position);
	assign at_pos    = (MY_IDX == pos_w);
	assign above_pos = (MY_IDX > pos_w);

	always_ff @(posedge clk) begin
		if (ctrl.ins_ok && at_pos) begin
			data_q <= ins_value;
		end else if (ctrl.ins_ok && above_pos) begin
			data_q <= left_data;
		end else if (ctrl.del_ok && (at_pos || above_pos)) begin
			data_q <= right_data;
		end
	end

	assign data     = data_q;
	assign hit_data = at_pos ? data_q : '0;

endmodule
`default_nettype wire

### rtl/positional_list_engine_top.sv
// Top level of the positional list engine: length control, cell row, result register.
//
// Channel   Direction  Handshake           Payload
// command   in         start && !busy      cmd   (kind, position, value)
// result    out        done, one cycle     rsp   (ok, read_value, length_after)
//
// The result beat appears the cycle after the command is accepted, and a new
// command may be accepted every cycle.
// All cells shift in the same cycle, so insert and delete cost no more than find.
// Reset empties the list; entries are not cleared and hold no meaning until written.
// busy stays low; the receiver cannot stall, so done is never held back.
`default_nettype none
module positional_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ple_pkg::cmd_t cmd,
	output logic               done,
	output ple_pkg::rsp_t      rsp
);
	import ple_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY) + 1;
	localparam int CW = (IW > POS_W) ? IW : POS_W;
	localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

	logic [LW-1:0]     len_q;
	logic [CW-1:0]     len_w;
	logic [CW-1:0]     pos_w;
	logic [CW-1:0]     len_next;
	logic              accept;
	logic              ins_ok;
	logic              del_ok;
	logic              find_ok;
	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_hit  [CAPACITY];
	logic [DATA_W-1:0] found;
	logic              done_q;
	rsp_t              rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign len_w  = CW'(len_q);
	assign pos_w  = CW'(cmd.position);

	assign ins_ok  = accept && (cmd.kind == KIND_INSERT) && (pos_w <= len_w) && (len_w < CAP_W);
	assign del_ok  = accept && (cmd.kind == KIND_DELETE) && (pos_w < len_w);
	assign find_ok = accept && (cmd.kind == KIND_FIND) && (pos_w < len_w);

	always_comb begin
		len_next = len_w;
		if (ins_ok) begin
			len_next = len_w + CW'(1);
		end else if (del_ok) begin
			len_next = len_w - CW'(1);
		end
	end

	assign ctrl.ins_ok   = ins_ok;
	assign ctrl.del_ok   = del_ok;
	assign ctrl.position = cmd.position;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;
			if (gi == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_mid_l
				assign left_d = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_mid_r
				assign right_d = cell_data[gi+1];
			end
			ple_cell #(
				.CAPACITY (CAPACITY),
				.IDX      (gi)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.ins_value  (cmd.value),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[gi]),
				.hit_data   (cell_hit[gi])
			);
		end
	endgenerate

	// merge the one matching cell's word
	always_comb begin
		found = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | cell_hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				len_q <= len_next[LW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.ok           <= ins_ok || del_ok || find_ok;
			rsp_q.read_value   <= find_ok ? found : '0;
			rsp_q.length_after <= len_next[POS_W-1:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result beat");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ok) |-> (rsp.read_value == '0))
		else $error("failed operation returned nonzero data");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CAP_W)
		else $error("list length above capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (CW'(len_q) == CW'($past(len_q)) + CW'(1)))
		else $error("insert did not grow the list");

	a_del_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		del_ok |=> (CW'(len_q) + CW'(1) == CW'($past(len_q))))
		else $error("delete did not shrink the list");

endmodule
`default_nettype wire
